FILE: hdl/fwr_pkg.sv
// ----------------------------------------------------------------------------
// fwr_pkg
// Shared types, codes and reset values of the four-wheel ratio PI compensator.
// ----------------------------------------------------------------------------
`default_nettype none

package fwr_pkg;

    localparam int INTEG_FRAC_BITS_DEF  = 16;
    localparam int EXPECT_FRAC_BITS_DEF = 8;

    localparam int NUM_WHEELS = 4;
    localparam int WORD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_LIM   = 2'd3;

    localparam logic [7:0]  PROP_GAIN_RST  = 8'd3;
    localparam logic [15:0] INTEG_GAIN_RST = 16'd655;
    localparam logic [14:0] INTEG_LIM_RST  = 15'd1000;
    localparam logic [14:0] COMP_LIM_RST   = 15'd4000;

    typedef struct packed {
        logic [7:0]  prop_gain;
        logic [15:0] integ_gain_q16;
        logic [14:0] integ_limit;
        logic [14:0] comp_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUMS,
        OP_MULQ,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ERR,
        OP_MULI,
        OP_INTEG,
        OP_MULP,
        OP_COMP,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] wheel;
    } cmd_t;

    typedef struct packed {
        logic tsum_zero;
        logic div_done;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMS,
        ST_MULQ,
        ST_DIVI,
        ST_DIV,
        ST_ERR,
        ST_MULI,
        ST_INTEG,
        ST_MULP,
        ST_COMP,
        ST_DONE
    } state_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fwr_ctrl.sv
// ----------------------------------------------------------------------------
// fwr_ctrl
// Sequencer: steps the datapath through the four wheels and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire               m_tready,
    input  fwr_pkg::status_t  status,
    output fwr_pkg::cmd_t     cmd
);

    fwr_pkg::state_t state_reg, state_next;
    logic [1:0]      wheel_reg, wheel_next;
    logic            valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fwr_pkg::ST_IDLE;
            wheel_reg <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        valid_next = valid_reg;
        cmd.op     = fwr_pkg::OP_NONE;
        cmd.wheel  = wheel_reg;
        s_tready   = (state_reg == fwr_pkg::ST_IDLE);
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            fwr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = fwr_pkg::OP_LOAD;
                    state_next = fwr_pkg::ST_SUMS;
                end
            end
            fwr_pkg::ST_SUMS: begin
                cmd.op     = fwr_pkg::OP_SUMS;
                wheel_next = 2'd0;
                state_next = fwr_pkg::ST_MULQ;
            end
            fwr_pkg::ST_MULQ: begin
                cmd.op = fwr_pkg::OP_MULQ;
                // zero target sum: expected speed is zero, skip the divide
                state_next = status.tsum_zero ? fwr_pkg::ST_ERR : fwr_pkg::ST_DIVI;
            end
            fwr_pkg::ST_DIVI: begin
                cmd.op     = fwr_pkg::OP_DIV_INIT;
                state_next = fwr_pkg::ST_DIV;
            end
            fwr_pkg::ST_DIV: begin
                if (status.div_done) begin
                    state_next = fwr_pkg::ST_ERR;
                end else begin
                    cmd.op = fwr_pkg::OP_DIV_STEP;
                end
            end
            fwr_pkg::ST_ERR: begin
                cmd.op     = fwr_pkg::OP_ERR;
                state_next = fwr_pkg::ST_MULI;
            end
            fwr_pkg::ST_MULI: begin
                cmd.op     = fwr_pkg::OP_MULI;
                state_next = fwr_pkg::ST_INTEG;
            end
            fwr_pkg::ST_INTEG: begin
                cmd.op     = fwr_pkg::OP_INTEG;
                state_next = fwr_pkg::ST_MULP;
            end
            fwr_pkg::ST_MULP: begin
                cmd.op     = fwr_pkg::OP_MULP;
                state_next = fwr_pkg::ST_COMP;
            end
            fwr_pkg::ST_COMP: begin
                cmd.op = fwr_pkg::OP_COMP;
                if (wheel_reg == 2'd3) begin
                    state_next = fwr_pkg::ST_DONE;
                end else begin
                    wheel_next = wheel_reg + 2'd1;
                    state_next = fwr_pkg::ST_MULQ;
                end
            end
            fwr_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!valid_reg || m_tready) begin
                    cmd.op     = fwr_pkg::OP_OUT;
                    valid_next = 1'b1;
                    state_next = fwr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fwr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire

FILE: hdl/fwr_dp.sv
// ----------------------------------------------------------------------------
// fwr_dp
// Datapath: sums, expected-speed divider, PI arithmetic, integrators, output.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_dp #(
    parameter int INTEG_FRAC_BITS  = fwr_pkg::INTEG_FRAC_BITS_DEF,
    parameter int EXPECT_FRAC_BITS = fwr_pkg::EXPECT_FRAC_BITS_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  fwr_pkg::cmd_t    cmd,
    input  fwr_pkg::cfg_t    cfg,
    input  wire  [191:0]     in_data,
    output fwr_pkg::status_t status,
    output logic [63:0]      out_data
);

    localparam int EF   = EXPECT_FRAC_BITS;
    localparam int IFB  = INTEG_FRAC_BITS;
    localparam int QW   = 18 + EF;
    localparam int RW   = 19;
    localparam int DW   = 34 + EF;
    localparam int CNTW = $clog2(QW + 1);
    localparam int EW   = 19 + EF;
    localparam int PW   = EW + 17;
    localparam int IS   = 16 + EF - IFB;
    localparam int RSH  = (IS > 0) ? IS : 0;
    localparam int LSH  = (IS < 0) ? -IS : 0;
    localparam int INCW = PW + LSH;
    localparam int IW   = 16 + IFB;
    localparam int SW   = fwr_pkg::max_int(INCW, IW) + 1;
    localparam int FMAX = fwr_pkg::max_int(EF, IFB);
    localparam int AW   = EW + 9;
    localparam int CW   = fwr_pkg::max_int(AW + FMAX - EF, IW + FMAX - IFB) + 1;

    logic signed [15:0]   tar_reg [4];
    logic signed [15:0]   meas_reg [4];
    logic signed [15:0]   base_reg [4];
    logic [17:0]          tsum_reg;
    logic [17:0]          fsum_reg;
    logic [33:0]          prodq_reg;
    logic [RW-1:0]        rem_reg;
    logic [QW-1:0]        dq_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [PW-1:0] pi_reg;
    logic signed [AW-1:0] pa_reg;
    logic signed [IW-1:0] integ_reg [4];
    logic signed [15:0]   drv_reg [4];
    logic [63:0]          out_reg;

    logic [17:0]          tsum_next, fsum_next;
    logic [15:0]          tmag;
    logic [DW-1:0]        dd;
    logic [RW-1:0]        trial;
    logic                 ge;
    logic signed [EW-1:0] qs, expect_v, measx, err_next;
    logic [PW-1:0]        pmag;
    logic [INCW-1:0]      incm;
    logic signed [SW-1:0] isum, ilim, iclamp;
    logic signed [CW-1:0] av, bv, csum, cmag_s, clim, cclamp;
    logic [CW-1:0]        cmag;
    logic signed [16:0]   drv_wide;
    logic signed [15:0]   drv_next;

    always_comb begin
        tsum_next = '0;
        fsum_next = '0;
        for (int i = 0; i < 4; i++) begin
            tsum_next = tsum_next + 18'(tar_reg[i][15] ? -tar_reg[i] : tar_reg[i]);
            fsum_next = fsum_next + 18'(meas_reg[i][15] ? -meas_reg[i] : meas_reg[i]);
        end
        tmag = tar_reg[cmd.wheel][15] ? 16'(-tar_reg[cmd.wheel]) : 16'(tar_reg[cmd.wheel]);

        dd    = DW'(prodq_reg) << EF;
        trial = {rem_reg[RW-2:0], dq_reg[QW-1]};
        ge    = (trial >= RW'(tsum_reg));

        qs       = status.tsum_zero ? '0 : $signed({1'b0, dq_reg});
        expect_v = tar_reg[cmd.wheel][15] ? -qs : qs;
        measx    = EW'(meas_reg[cmd.wheel]) <<< EF;
        err_next = expect_v - measx;

        // integrator increment, truncated toward zero
        pmag   = pi_reg[PW-1] ? PW'(-pi_reg) : PW'(pi_reg);
        incm   = INCW'(pmag >> RSH) << LSH;
        isum   = SW'(integ_reg[cmd.wheel])
               + (pi_reg[PW-1] ? -$signed(SW'(incm)) : $signed(SW'(incm)));
        ilim   = $signed(SW'({cfg.integ_limit, {IFB{1'b0}}}));
        iclamp = (isum > ilim) ? ilim : ((isum < -ilim) ? -ilim : isum);

        av     = CW'(pa_reg) <<< (FMAX - EF);
        bv     = CW'(integ_reg[cmd.wheel]) <<< (FMAX - IFB);
        csum   = av + bv;
        cmag   = CW'(csum[CW-1] ? -csum : csum) >> FMAX;
        cmag_s = csum[CW-1] ? -$signed(cmag) : $signed(cmag);
        clim   = $signed(CW'(cfg.comp_limit));
        cclamp = (cmag_s > clim) ? clim : ((cmag_s < -clim) ? -clim : cmag_s);

        drv_wide = 17'(base_reg[cmd.wheel]) + 17'(cclamp);
        if (drv_wide > 17'sd32767) begin
            drv_next = 16'sh7FFF;
        end else if (drv_wide < -17'sd32768) begin
            drv_next = 16'sh8000;
        end else begin
            drv_next = 16'(drv_wide);
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            fwr_pkg::OP_LOAD: begin
                for (int i = 0; i < 4; i++) begin
                    tar_reg[i]  <= in_data[16*i +: 16];
                    meas_reg[i] <= in_data[64 + 16*i +: 16];
                    base_reg[i] <= in_data[128 + 16*i +: 16];
                end
            end
            fwr_pkg::OP_SUMS: begin
                tsum_reg <= tsum_next;
                fsum_reg <= fsum_next;
            end
            fwr_pkg::OP_MULQ: begin
                prodq_reg <= 34'(fsum_reg) * 34'(tmag);
            end
            fwr_pkg::OP_DIV_INIT: begin
                rem_reg <= RW'(dd[DW-1:QW]);
                dq_reg  <= dd[QW-1:0];
                cnt_reg <= CNTW'(QW);
            end
            fwr_pkg::OP_DIV_STEP: begin
                rem_reg <= ge ? (trial - RW'(tsum_reg)) : trial;
                dq_reg  <= {dq_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            fwr_pkg::OP_ERR: begin
                err_reg <= err_next;
            end
            fwr_pkg::OP_MULI: begin
                pi_reg <= PW'($signed({1'b0, cfg.integ_gain_q16})) * PW'(err_reg);
            end
            fwr_pkg::OP_MULP: begin
                pa_reg <= AW'($signed({1'b0, cfg.prop_gain})) * AW'(err_reg);
            end
            fwr_pkg::OP_COMP: begin
                drv_reg[cmd.wheel] <= drv_next;
            end
            fwr_pkg::OP_OUT: begin
                out_reg <= {drv_reg[3], drv_reg[2], drv_reg[1], drv_reg[0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                integ_reg[i] <= '0;
            end
        end else if (cmd.op == fwr_pkg::OP_INTEG) begin
            integ_reg[cmd.wheel] <= IW'(iclamp);
        end
    end

    assign status.tsum_zero = (tsum_reg == '0);
    assign status.div_done  = (cnt_reg == '0);
    assign out_data         = out_reg;

endmodule

`default_nettype wire

FILE: hdl/four_wheel_ratio_pi_compensator.sv
// ----------------------------------------------------------------------------
// four_wheel_ratio_pi_compensator
// Ratio-based per-wheel PI speed compensation for a four-wheel drive.
// ----------------------------------------------------------------------------
// One transaction at a time: after accept the four wheels are worked in turn,
// each through the expected-speed divider (one quotient bit per cycle), which
// is skipped when all targets are zero. The next transaction is taken once the
// result is in the output register, also while that result still waits.
// Reset (aresetn low, synchronous): registers to defaults, integrators to zero.
`default_nettype none

module four_wheel_ratio_pi_compensator #(
    parameter int INTEG_FRAC_BITS  = fwr_pkg::INTEG_FRAC_BITS_DEF,
    parameter int EXPECT_FRAC_BITS = fwr_pkg::EXPECT_FRAC_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // target_front_left, target_front_right, target_back_left, target_back_right,
    // measured_front_left .. measured_back_right, base_front_left .. base_back_right
    input  wire [191:0] s_tdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // drive_front_left, drive_front_right, drive_back_left, drive_back_right
    output logic [63:0] m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    fwr_pkg::cfg_t    cfg_reg;
    fwr_pkg::cmd_t    cmd;
    fwr_pkg::status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= fwr_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain_q16 <= fwr_pkg::INTEG_GAIN_RST;
            cfg_reg.integ_limit    <= fwr_pkg::INTEG_LIM_RST;
            cfg_reg.comp_limit     <= fwr_pkg::COMP_LIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fwr_pkg::REG_PROP_GAIN:  cfg_reg.prop_gain      <= cfg_data[7:0];
                fwr_pkg::REG_INTEG_GAIN: cfg_reg.integ_gain_q16 <= cfg_data;
                fwr_pkg::REG_INTEG_LIM:  cfg_reg.integ_limit    <= cfg_data[14:0];
                fwr_pkg::REG_COMP_LIM:   cfg_reg.comp_limit     <= cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    fwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fwr_dp #(
        .INTEG_FRAC_BITS  (INTEG_FRAC_BITS),
        .EXPECT_FRAC_BITS (EXPECT_FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .status   (status),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire
